// ----- design/mwo_pkg.sv -----
`timescale 1ns / 1ps
package mwo_pkg;
   localparam int TABLE_SIZE_DEF = 512;
   localparam int MIP_LEVELS_DEF = 8;
   localparam int INDEX_W = 9;
   localparam logic [17:0] DEFAULT_RATE = 18'd48000;
   localparam logic [16:0] FULL_WEIGHT = 17'd65536;
   localparam logic [23:0] LEVEL_BASE = 24'd14080;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_FREQ  = 2'd1,
      ACT_WRITE = 2'd2,
      ACT_SWAP  = 2'd3
   } action_type;

   typedef enum logic [0:0] {
      CSR_RATE   = 1'b0,
      CSR_BRIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      action_type   action;
      logic [23:0]  frequency_hz;
      logic         table_buffer;
      logic         table_tone;
      logic [2:0]   table_level;
      logic [8:0]   table_index;
      logic [15:0]  table_value;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               live_buffer;
   } rsp_word_type;
endpackage

// ----- design/mwo_if.sv -----
`timescale 1ns / 1ps
interface mwo_req_if;
   import mwo_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface mwo_rsp_if;
   import mwo_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface mwo_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/mipmapped_wavetable_oscillator.sv -----
`timescale 1ns / 1ps
// Wavetable oscillator with two table buffers and mip levels. Words enter a
// two-entry queue and run one at a time: a playing tick runs S_RD0 to S_RD3
// (four reads of the single table memory port), then interpolation and
// crossfade in S_MIX and S_OUT; a set-frequency word waits in S_DIV for the
// bit-serial divider; writes, swaps and silent ticks end in S_IDLE. Tables are
// not cleared after reset; read only entries that were written.
module mipmapped_wavetable_oscillator #(
   parameter int MIP_LEVELS = mwo_pkg::MIP_LEVELS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mwo_req_if.sink    req,
   mwo_rsp_if.source  rsp,
   mwo_csr_if.sink    csr
);
   import mwo_pkg::*;
   logic [17:0] rate_ff;
   logic [16:0] bright_ff;
   logic q_valid, q_ready;
   req_word_type q_word;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= DEFAULT_RATE;
         bright_ff <= '0;
      end else if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_RATE: rate_ff <= csr.data[17:0];
            CSR_BRIGHT: bright_ff <= csr.data[16:0];
            default: ;
         endcase
      end
   end

   mwo_queue u_queue (.clock(clock), .reset(reset), .in_valid(req.valid),
      .in_ready(req.ready), .in_word(req.payload), .out_valid(q_valid),
      .out_ready(q_ready), .out_word(q_word));

   mwo_back #(.MIP_LEVELS(MIP_LEVELS)) u_back (.clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_word(q_word),
      .sample_rate(rate_ff), .brightness(bright_ff), .out_valid(rsp.valid),
      .out_ready(rsp.ready), .out_word(rsp.payload));
endmodule

// ----- design/mwo_queue.sv -----
`timescale 1ns / 1ps
module mwo_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mwo_pkg::req_word_type in_word,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mwo_pkg::req_word_type out_word
);
   import mwo_pkg::*;
   req_word_type mem_ff [2];
   logic [1:0] wp_ff, rp_ff;
   logic [1:0] wp_in, rp_in;
   logic push, pop;

   assign in_ready = (wp_ff - rp_ff) != 2'd2;
   assign out_valid = wp_ff != rp_ff;
   assign out_word = mem_ff[rp_ff[0]];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign wp_in = wp_ff + {1'b0, push};
   assign rp_in = rp_ff + {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
      if (push) mem_ff[wp_ff[0]] <= in_word;
   end

`ifndef SYNTHESIS
   a_count: assert property (@(posedge clock) disable iff (reset)
      (wp_ff - rp_ff) <= 2'd2) else $error("queue overrun");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid) else $error("queue lost word");
   a_full: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> out_valid) else $error("full but empty");
`endif
endmodule

// ----- design/mwo_divider.sv -----
`timescale 1ns / 1ps
module mwo_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [23:0] freq,
   input  logic [17:0] rate,
   output logic        done,
   output logic [31:0] quotient
);
   logic [47:0] num_ff, num_in;
   logic [18:0] rem_ff, rem_in;
   logic [17:0] den_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [19:0] trial;
   logic [18:0] shifted;

   assign shifted = {rem_ff[17:0], num_ff[47]};
   assign trial = {1'b0, shifted} - {2'b00, den_ff};

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done = 1'b0;
      if (start) begin
         num_in = {freq, 24'd0};
         rem_in = '0;
         cnt_in = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done = 1'b1;
         end else begin
            if (!trial[19]) begin
               rem_in = trial[18:0];
               num_in = {num_ff[46:0], 1'b1};
            end else begin
               rem_in = shifted;
               num_in = {num_ff[46:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   // the quotient bits above 32 sit in num_ff[47:32] once finished
   assign quotient = (num_ff[47:32] != '0) ? 32'hFFFF_FFFF : num_ff[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      if (start) den_ff <= rate;
   end
endmodule

// ----- design/mwo_back.sv -----
`timescale 1ns / 1ps
module mwo_back #(
   parameter int MIP_LEVELS = mwo_pkg::MIP_LEVELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mwo_pkg::req_word_type in_word,
   input  logic [17:0]           sample_rate,
   input  logic [16:0]           brightness,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mwo_pkg::rsp_word_type out_word
);
   import mwo_pkg::*;
   localparam int LW = (MIP_LEVELS > 1) ? $clog2(MIP_LEVELS) : 1;
   localparam int DEPTH = 4 * (1 << LW) * TABLE_SIZE_DEF;
   localparam int AW = $clog2(DEPTH);

   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001, S_DIV  = 8'b00000010, S_RD0  = 8'b00000100,
      S_RD1  = 8'b00001000, S_RD2  = 8'b00010000, S_RD3  = 8'b00100000,
      S_MIX  = 8'b01000000, S_OUT  = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [15:0] mem [DEPTH];
   logic [15:0] rd_ff;
   logic [AW-1:0] raddr;
   logic [31:0] phase_ff, phase_in, inc_ff, inc_in;
   logic [LW-1:0] lvl_ff, lvl_in, lvl_new;
   logic act_ff, act_in, built_ff, built_in;
   logic signed [15:0] a_ff, b_ff;
   logic signed [16:0] dv_ff, bv_ff;
   logic signed [33:0] prod;
   logic signed [16:0] lerp;
   logic out_v_ff, out_v_in;
   rsp_word_type out_ff, out_in;
   logic [17:0] rate_eff;
   logic div_start, div_done;
   logic [31:0] quot;
   logic [8:0] idx_i, idx_n;
   logic [16:0] w;
   logic signed [16:0] diff;
   logic signed [17:0] mix;
   logic [AW-1:0] waddr;
   logic wr_en;

   assign rate_eff = (sample_rate == '0) ? DEFAULT_RATE : sample_rate;
   assign idx_i = phase_ff[31:23];
   assign idx_n = idx_i + 9'd1;
   assign w = (brightness > FULL_WEIGHT) ? FULL_WEIGHT : brightness;

   mwo_divider u_div (.clock(clock), .reset(reset), .start(div_start),
      .freq(in_word.frequency_hz), .rate(rate_eff), .done(div_done), .quotient(quot));

   always_comb begin
      lvl_new = '0;
      for (int k = 0; k < MIP_LEVELS; k++)
         if ({8'd0, in_word.frequency_hz} >= ({8'd0, LEVEL_BASE} << k)) lvl_new = LW'(k);
   end

   always_comb begin
      case (state_ff)
         S_RD0: raddr = AW'({act_ff, 1'b0, lvl_ff, idx_i});
         S_RD1: raddr = AW'({act_ff, 1'b0, lvl_ff, idx_n});
         S_RD2: raddr = AW'({act_ff, 1'b1, lvl_ff, idx_i});
         default: raddr = AW'({act_ff, 1'b1, lvl_ff, idx_n});
      endcase
   end

   assign waddr = AW'({in_word.table_buffer, in_word.table_tone,
                       LW'(in_word.table_level), in_word.table_index});
   assign wr_en = state_ff == S_IDLE && in_valid && in_word.action == ACT_WRITE
                  && {29'd0, in_word.table_level} < MIP_LEVELS;

   // lerp of the word pair held in a_ff and rd_ff
   assign diff = 17'($signed(rd_ff)) - 17'(a_ff);
   assign prod = diff * $signed({1'b0, phase_ff[22:7]});
   assign lerp = 17'(a_ff) + 17'(prod >>> 16);

   always_comb begin
      logic signed [34:0] p2;
      p2 = (bv_ff - dv_ff) * $signed({1'b0, w});
      mix = 18'(dv_ff) + 18'(p2 >>> 16);
   end

   assign in_ready = state_ff == S_IDLE && !(out_v_ff && !out_ready && in_word.action == ACT_TICK);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      inc_in = inc_ff;
      lvl_in = lvl_ff;
      act_in = act_ff;
      built_in = built_ff;
      out_v_in = out_v_ff && !out_ready;
      out_in = out_ff;
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: if (in_valid && in_ready) begin
            case (in_word.action)
               ACT_FREQ: if (in_word.frequency_hz == '0) inc_in = '0;
                  else begin
                     div_start = 1'b1;
                     lvl_in = lvl_new;
                     state_in = S_DIV;
                  end
               ACT_SWAP: begin
                  act_in = !act_ff;
                  built_in = 1'b1;
               end
               ACT_TICK: if (built_ff && inc_ff != '0) state_in = S_RD0;
                  else begin
                     out_v_in = 1'b1;
                     out_in = '{sample: '0, live_buffer: act_ff};
                  end
               default: ;
            endcase
         end
         S_DIV: if (div_done) state_in = S_IDLE;
         S_RD0: state_in = S_RD1;
         S_RD1: state_in = S_RD2;
         S_RD2: state_in = S_RD3;
         S_RD3: state_in = S_MIX;
         S_MIX: state_in = S_OUT;
         S_OUT: begin
            out_v_in = 1'b1;
            out_in.live_buffer = act_ff;
            if (mix > 18'sd32767) out_in.sample = 16'sd32767;
            else if (mix < -18'sd32768) out_in.sample = -16'sd32768;
            else out_in.sample = 16'(mix);
            phase_in = phase_ff + inc_ff;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_DIV && div_done) inc_in = quot;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[waddr] <= in_word.table_value;
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= '0;
         inc_ff <= '0;
         lvl_ff <= '0;
         act_ff <= 1'b0;
         built_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         inc_ff <= inc_in;
         lvl_ff <= lvl_in;
         act_ff <= act_in;
         built_ff <= built_in;
         out_v_ff <= out_v_in;
      end
      out_ff <= out_in;
      // rd_ff carries the word read in the previous state
      if (state_ff == S_RD1) a_ff <= rd_ff;
      if (state_ff == S_RD2) dv_ff <= lerp;
      if (state_ff == S_RD3) a_ff <= rd_ff;
      if (state_ff == S_MIX) bv_ff <= lerp;
   end

   // hold the bright lerp from S_MIX in bv_ff and blend in S_OUT
   assign out_valid = out_v_ff;
   assign out_word = out_ff;

`ifndef SYNTHESIS
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !out_ready |=> out_v_ff && $stable(out_ff)) else $error("result dropped");
   a_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_OUT |=> phase_ff == $past(phase_ff)) else $error("phase moved");
`endif
endmodule

// ----- test/tb_mipmapped_wavetable_oscillator.sv -----
`timescale 1ns / 1ps
module tb_mipmapped_wavetable_oscillator;
   import mwo_pkg::*;

   logic clock;
   logic reset;

   mwo_req_if req_ch();
   mwo_rsp_if rsp_ch();
   mwo_csr_if csr_ch();

   mipmapped_wavetable_oscillator dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source),
      .csr(csr_ch.sink)
   );

   typedef struct {
      logic [15:0] sample;
      logic        live_buffer;
      logic        typed;
   } sample_exp_type;

   typedef struct {
      action_type  action;
      logic [23:0] hz;
      logic        buffer;
      logic        tone;
      logic [2:0]  level;
      logic [8:0]  index;
      logic [15:0] value;
      logic        typed;
      logic [15:0] sample;
      logic        live_buffer;
   } stim_row_type;

   logic [17:0] osc_rate;
   logic [16:0] osc_bright;
   logic [31:0] osc_phase;
   logic [31:0] osc_incr;
   logic [2:0]  osc_level;
   logic        osc_live;
   logic        osc_built;
   logic [15:0] osc_tables [0:16383];
   logic        osc_written [0:16383];

   sample_exp_type sample_queue[$];
   int  errors;
   int  cycle_count;
   int  send_idle_pct;
   int  recv_idle_pct;
   bit  hold_recv;
   int  hold_cycles;
   int  sent_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 2000000) begin
            $display("tb_mipmapped_wavetable_oscillator failed");
            $finish;
         end
      end
   end

   function automatic int table_addr(logic b, logic t, logic [2:0] l, logic [8:0] i);
      return {b, t, l, i};
   endfunction

   function automatic logic signed [31:0] fold_q16(logic signed [47:0] x);
      return 32'(x >>> 16);
   endfunction

   function automatic logic signed [31:0] interp_tone(logic t, logic [8:0] i, logic [8:0] n,
                                                     logic [15:0] fr);
      logic signed [31:0] a;
      logic signed [31:0] b;
      a = 32'(signed'(osc_tables[table_addr(osc_live, t, osc_level, i)]));
      b = 32'(signed'(osc_tables[table_addr(osc_live, t, osc_level, n)]));
      return a + fold_q16(48'(b - a) * 48'(signed'({1'b0, fr})));
   endfunction

   function automatic void osc_apply(stim_row_type r, output bit has, output logic [15:0] s,
                                     output logic lb);
      logic [63:0] q;
      logic [17:0] sr;
      logic [8:0]  i;
      logic [8:0]  n;
      logic [16:0] w;
      logic signed [31:0] dv;
      logic signed [31:0] bv;
      logic signed [31:0] v;
      has = 0;
      s = '0;
      lb = osc_live;
      case (r.action)
         ACT_FREQ: begin
            if (r.hz == 0) osc_incr = '0;
            else begin
               sr = (osc_rate == 0) ? DEFAULT_RATE : osc_rate;
               q = {16'd0, r.hz, 24'd0} / 64'(sr);
               osc_incr = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
               osc_level = '0;
               for (int k = 0; k < 8; k++)
                  if (64'(r.hz) >= (64'(LEVEL_BASE) << k)) osc_level = 3'(k);
            end
         end
         ACT_WRITE: begin
            osc_tables[table_addr(r.buffer, r.tone, r.level, r.index)] = r.value;
            osc_written[table_addr(r.buffer, r.tone, r.level, r.index)] = 1'b1;
         end
         ACT_SWAP: begin
            osc_live = ~osc_live;
            osc_built = 1'b1;
         end
         default: begin
            has = 1;
            v = 0;
            if (osc_built && osc_incr != 0) begin
               i = osc_phase[31:23];
               n = i + 9'd1;
               w = (osc_bright > FULL_WEIGHT) ? FULL_WEIGHT : osc_bright;
               dv = interp_tone(1'b0, i, n, osc_phase[22:7]);
               bv = interp_tone(1'b1, i, n, osc_phase[22:7]);
               v = dv + fold_q16(48'(bv - dv) * 48'(signed'({1'b0, w})));
               if (v > 32767) v = 32767;
               if (v < -32768) v = -32768;
               osc_phase = osc_phase + osc_incr;
            end
            s = v[15:0];
         end
      endcase
   endfunction

   task automatic put_word(stim_row_type r);
      bit has;
      logic [15:0] s;
      logic lb;
      sample_exp_type e;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.payload <= '{r.action, r.hz, r.buffer, r.tone, r.level, r.index, r.value};
      req_ch.valid <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count++;
      osc_apply(r, has, s, lb);
      if (has) begin
         e.sample = r.typed ? r.sample : s;
         e.live_buffer = r.typed ? r.live_buffer : lb;
         e.typed = r.typed;
         sample_queue.push_back(e);
      end
   endtask

   function automatic stim_row_type mk(action_type a, logic [23:0] hz = 0, logic b = 0,
                                       logic t = 0, logic [2:0] l = 0, logic [8:0] i = 0,
                                       logic [15:0] v = 0);
      stim_row_type r;
      r = '{a, hz, b, t, l, i, v, 1'b0, 16'd0, 1'b0};
      return r;
   endfunction

   task automatic prime_entry(logic t, logic [8:0] i);
      if (!osc_written[table_addr(osc_live, t, osc_level, i)])
         put_word(mk(ACT_WRITE, '0, osc_live, t, osc_level, i,
                     16'($urandom_range(64000) - 32000)));
   endtask

   task automatic prime_tick();
      logic [8:0] i;
      logic [8:0] n;
      i = osc_phase[31:23];
      n = i + 9'd1;
      if (osc_built && osc_incr != 0) begin
         prime_entry(1'b0, i);
         prime_entry(1'b0, n);
         prime_entry(1'b1, i);
         prime_entry(1'b1, n);
      end
   endtask

   task automatic send_word(stim_row_type r);
      if (r.action == ACT_TICK) prime_tick();
      put_word(r);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] val);
      csr_ch.index <= idx;
      csr_ch.data <= val;
      csr_ch.valid <= 1'b1;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_RATE) osc_rate = val[17:0];
      else osc_bright = val[16:0];
      @(posedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (sample_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic stim_row_type mk_tick_exp(logic [15:0] s, logic lb);
      stim_row_type r;
      r = mk(ACT_TICK);
      r.typed = 1'b1;
      r.sample = s;
      r.live_buffer = lb;
      return r;
   endfunction

   task automatic random_word(int pct_tick);
      stim_row_type r;
      int roll;
      logic [23:0] hz;
      roll = $urandom_range(99);
      if (roll < pct_tick) r = mk(ACT_TICK, 24'($urandom), 1'($urandom), 1'($urandom),
                                  3'($urandom), 9'($urandom), 16'($urandom));
      else if (roll < pct_tick + 8) begin
         case ($urandom_range(3))
            0: hz = 24'($urandom);
            1: hz = 24'($urandom_range(40000));
            2: hz = 24'hFF_FFFF;
            default: hz = 24'($urandom_range(3000000));
         endcase
         r = mk(ACT_FREQ, hz, 1'($urandom), 1'($urandom), 3'($urandom), 9'($urandom),
                16'($urandom));
      end else if (roll < pct_tick + 12)
         r = mk(ACT_SWAP, 24'($urandom), 1'($urandom), 1'($urandom), 3'($urandom),
                9'($urandom), 16'($urandom));
      else
         r = mk(ACT_WRITE, 24'($urandom), 1'($urandom), 1'($urandom), 3'($urandom),
                9'($urandom), 16'($urandom_range(64000) - 32000));
      send_word(r);
   endtask

   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else if (hold_recv) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      sample_exp_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (sample_queue.size() == 0) begin
            $display("%0t: unexpected word sample=%h", $time, rsp_ch.payload.sample);
            errors++;
         end else begin
            e = sample_queue.pop_front();
            if (rsp_ch.payload.sample !== e.sample) begin
               $display("%0t: sample expected %h actual %h", $time, e.sample,
                        rsp_ch.payload.sample);
               errors++;
            end
            if (rsp_ch.payload.live_buffer !== e.live_buffer) begin
               $display("%0t: live_buffer expected %b actual %b", $time, e.live_buffer,
                        rsp_ch.payload.live_buffer);
               errors++;
            end
         end
      end
   end

   stim_row_type directed [$];

   initial begin
      int target;
      errors = 0;
      sent_count = 0;
      hold_recv = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = 1'b0;
      csr_ch.data = '0;
      osc_rate = DEFAULT_RATE;
      osc_bright = '0;
      osc_phase = '0;
      osc_incr = '0;
      osc_level = '0;
      osc_live = 1'b0;
      osc_built = 1'b0;
      for (int k = 0; k < 16384; k++) begin
         osc_tables[k] = '0;
         osc_written[k] = 1'b0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed.push_back(mk_tick_exp(16'd0, 1'b0));
      directed.push_back(mk(ACT_FREQ, 24'd0));
      directed.push_back(mk_tick_exp(16'd0, 1'b0));
      directed.push_back(mk(ACT_SWAP));
      directed.push_back(mk_tick_exp(16'd0, 1'b1));
      directed.push_back(mk(ACT_SWAP));
      directed.push_back(mk(ACT_FREQ, 24'hFF_FFFF));
      directed.push_back(mk(ACT_FREQ, 24'd14079));
      directed.push_back(mk(ACT_FREQ, 24'd14080));
      directed.push_back(mk(ACT_FREQ, 24'd1));
      foreach (directed[k]) send_word(directed[k]);

      directed.delete();
      directed.push_back(mk(ACT_FREQ, 24'd42240));
      directed.push_back(mk(ACT_TICK));
      directed.push_back(mk(ACT_TICK));
      directed.push_back(mk(ACT_FREQ, 24'hFF_FFFF));
      directed.push_back(mk(ACT_TICK));
      directed.push_back(mk(ACT_TICK));
      directed.push_back(mk(ACT_FREQ, 24'd0));
      directed.push_back(mk(ACT_TICK));
      directed.push_back(mk(ACT_SWAP));
      directed.push_back(mk(ACT_FREQ, 24'd5000));
      directed.push_back(mk(ACT_TICK));
      foreach (directed[k]) send_word(directed[k]);
      drain_results();

      for (int ph = 0; ph < 6; ph++) begin
         drain_results();
         case (ph)
            0: begin write_reg(CSR_RATE, 32'd0); write_reg(CSR_BRIGHT, 32'd65536); end
            1: begin write_reg(CSR_RATE, 32'd192000); write_reg(CSR_BRIGHT, 32'h1FFFF); end
            2: begin write_reg(CSR_RATE, 32'd1); write_reg(CSR_BRIGHT, 32'd0); end
            3: begin write_reg(CSR_RATE, 32'($urandom_range(192000)));
               write_reg(CSR_BRIGHT, 32'($urandom_range(65536))); end
            4: begin write_reg(CSR_RATE, 32'h3FFFF); write_reg(CSR_BRIGHT, 32'd32768); end
            default: begin write_reg(CSR_RATE, 32'd44100);
               write_reg(CSR_BRIGHT, 32'($urandom)); end
         endcase
         send_idle_pct = (ph < 2) ? 36 : (ph < 4) ? 87 : 0;
         recv_idle_pct = (ph < 2) ? 87 : (ph < 4) ? 36 : 0;
         if (ph == 4) begin
            fork
               begin
                  hold_recv = 1;
                  hold_cycles = 0;
                  while (hold_cycles < 400) begin
                     @(posedge clock);
                     hold_cycles++;
                  end
                  hold_recv = 0;
               end
            join_none
         end
         target = sent_count + 225;
         while (sent_count < target) random_word(75);
         if (ph == 2) drain_results();
      end
      drain_results();
      if (errors == 0)
         $display("tb_mipmapped_wavetable_oscillator passed");
      else
         $display("tb_mipmapped_wavetable_oscillator failed");
      $finish;
   end
endmodule

// ----- files.f -----
design/mwo_pkg.sv
design/mwo_if.sv
design/mwo_queue.sv
design/mwo_divider.sv
design/mwo_back.sv
design/mipmapped_wavetable_oscillator.sv
test/tb_mipmapped_wavetable_oscillator.sv
